### hdl/bmprld_pkg.sv
// Shared types and constants for the BMP run-length decoder.
// No dependencies; used by bmp_run_length_decoder.
`default_nettype none

package bmprld_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int BYTE_W   = 8;
    localparam int POS_W    = 12;
    localparam int HEIGHT_W = 13;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BIT_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 1'd1;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd1;

    localparam logic [BYTE_W-1:0] ESC_END_LINE   = 8'h00;
    localparam logic [BYTE_W-1:0] ESC_END_BITMAP = 8'h01;
    localparam logic [BYTE_W-1:0] ESC_DELTA      = 8'h02;

    typedef enum logic [6:0] {
        PH_COUNT   = 7'b0000001,
        PH_VALUE   = 7'b0000010,
        PH_ESCAPE  = 7'b0000100,
        PH_DELTA_X = 7'b0001000,
        PH_DELTA_Y = 7'b0010000,
        PH_ABS     = 7'b0100000,
        PH_PAD     = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic              image_done;
        logic [BYTE_W-1:0] second_index;
        logic [BYTE_W-1:0] first_index;
        logic [BYTE_W-1:0] run_length;
        logic [POS_W-1:0]  start_column;
        logic [POS_W-1:0]  row;
    } t_result;

endpackage

`default_nettype wire

### hdl/bmp_run_length_decoder.sv
// BMP RLE8 / RLE4 pixel data decoder, top level.
// Depends on bmprld_pkg.
//
// Usage:
//   Slave stream (i_s_*) carries one compressed pixel byte per transaction;
//   tuser flags the first byte of a frame and restarts the parser at row 0,
//   column 0 before that byte is handled.
//   Master stream (o_m_*) carries one run record per painted run or absolute
//   data byte; tlast marks the record that ends the image (end of bitmap, or
//   a line end or delta that leaves the last row). After that record, bytes
//   are consumed and dropped until the next frame start.
//   Configuration (i_cfg_*) sets 4-bit mode and image height; write only
//   while the streams are idle.
// o_m_* is registered. Throughput: one byte per cycle while the skid
//   entry is empty; the decode of a byte is a single pass of phase logic
//   plus one saturating column add and one row add/compare.
// Stall: an output register plus a one-entry skid buffer hold records while
//   i_m_tready is low; o_s_tready drops while the skid entry is full.
// Reset: clears parser, position, done flag and both output entries, and
//   sets 8-bit mode with image height 1.
`default_nettype none

module bmp_run_length_decoder #(
    parameter int MAX_WIDTH  = bmprld_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmprld_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [bmprld_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  wire logic [bmprld_pkg::CFG_W-1:0]     i_cfg_data,
    // slave stream
    input  wire logic                             i_s_tvalid,
    output      logic                             o_s_tready,
    input  wire logic [7:0]                       i_s_tdata,  // [7:0] data_byte
    input  wire logic                             i_s_tuser,  // [0] frame_start
    // master stream
    output      logic                             o_m_tvalid,
    input  wire logic                             i_m_tready,
    // [11:0] row, [23:12] start_column, [31:24] run_length,
    // [39:32] first_index, [47:40] second_index
    output      logic [47:0]                      o_m_tdata,
    output      logic                             o_m_tlast   // image_done
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int CSUM_W = ((COL_W > 8) ? COL_W : 8) + 1;
    localparam int RSUM_W = ((ROW_W > 13) ? ROW_W : 13) + 1;
    localparam logic [CSUM_W-1:0] COL_LAST  = CSUM_W'(MAX_WIDTH - 1);
    localparam logic [RSUM_W-1:0] ROW_LIMIT = RSUM_W'(MAX_HEIGHT);

    // configuration registers
    logic                                r_four_bit_mode;
    logic [bmprld_pkg::HEIGHT_W-1:0]     r_image_height;

    // parser state
    bmprld_pkg::t_phase r_phase, n_phase;
    logic [7:0]         r_pending, n_pending;
    logic [7:0]         r_pix_left, n_pix_left;
    logic               r_pad, n_pad;
    logic [7:0]         r_delta_col, n_delta_col;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic               r_done, n_done;

    // output stage
    bmprld_pkg::t_result r_out, r_skid, res;
    logic                r_out_valid, r_skid_valid;
    logic                res_valid;

    logic               accept;
    logic               out_take;
    logic [7:0]         b;
    logic [3:0]         hi, lo;
    logic [8:0]         b_inc;
    logic [COL_W-1:0]   col_base;
    logic [ROW_W-1:0]   row_base;
    logic [7:0]         col_adv;
    logic               do_adv;
    logic               col_clr;
    logic [7:0]         row_adv;
    logic [CSUM_W-1:0]  col_sum;
    logic [RSUM_W-1:0]  row_sum;
    logic [RSUM_W-1:0]  height;
    logic               row_end;
    logic               emit;
    logic               emit_done;
    logic [7:0]         emit_len;
    logic [7:0]         emit_a;
    logic [7:0]         emit_b;
    logic [COL_W+11:0]  col_ext;
    logic [ROW_W+11:0]  row_ext;

    assign o_s_tready = !r_skid_valid;
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_take   = r_out_valid && i_m_tready;

    assign b     = i_s_tdata;
    assign hi    = b[7:4];
    assign lo    = b[3:0];
    assign b_inc = {1'b0, b} + 9'd1;

    always_comb begin
        height = RSUM_W'(r_image_height);
        if (height == '0) begin
            height = RSUM_W'(1);
        end else if (height > ROW_LIMIT) begin
            height = ROW_LIMIT;
        end
    end

    assign col_base = i_s_tuser ? '0 : r_col;
    assign row_base = i_s_tuser ? '0 : r_row;

    always_comb begin
        n_phase     = r_phase;
        n_pending   = r_pending;
        n_pix_left  = r_pix_left;
        n_pad       = r_pad;
        n_delta_col = r_delta_col;
        n_done      = r_done;
        n_row       = row_base;
        col_adv     = '0;
        do_adv      = 1'b0;
        col_clr     = 1'b0;
        row_adv     = 8'd1;
        emit        = 1'b0;
        emit_done   = 1'b0;
        emit_len    = '0;
        emit_a      = '0;
        emit_b      = '0;

        if (i_s_tuser) begin
            n_phase     = bmprld_pkg::PH_COUNT;
            n_pending   = '0;
            n_pix_left  = '0;
            n_pad       = 1'b0;
            n_delta_col = '0;
            n_done      = 1'b0;
        end

        if (n_phase == bmprld_pkg::PH_DELTA_Y) begin
            row_adv = b;
        end
        row_sum = RSUM_W'(row_base) + RSUM_W'(row_adv);
        row_end = row_sum >= height;

        if (!n_done) begin
            case (n_phase)
                bmprld_pkg::PH_COUNT: begin
                    if (b != 8'd0) begin
                        n_pending = b;
                        n_phase   = bmprld_pkg::PH_VALUE;
                    end else begin
                        n_phase = bmprld_pkg::PH_ESCAPE;
                    end
                end
                bmprld_pkg::PH_VALUE: begin
                    emit      = 1'b1;
                    emit_len  = n_pending;
                    emit_a    = r_four_bit_mode ? {4'd0, hi} : b;
                    emit_b    = r_four_bit_mode ? {4'd0, lo} : b;
                    col_adv   = n_pending;
                    do_adv    = 1'b1;
                    n_pending = '0;
                    n_phase   = bmprld_pkg::PH_COUNT;
                end
                bmprld_pkg::PH_ESCAPE: begin
                    if (b == bmprld_pkg::ESC_END_LINE) begin
                        if (row_end) begin
                            emit      = 1'b1;
                            emit_done = 1'b1;
                        end else begin
                            n_row   = row_sum[ROW_W-1:0];
                            col_clr = 1'b1;
                            n_phase = bmprld_pkg::PH_COUNT;
                        end
                    end else if (b == bmprld_pkg::ESC_END_BITMAP) begin
                        emit      = 1'b1;
                        emit_done = 1'b1;
                    end else if (b == bmprld_pkg::ESC_DELTA) begin
                        n_phase = bmprld_pkg::PH_DELTA_X;
                    end else begin
                        n_pix_left = b;
                        n_pad      = r_four_bit_mode ? b_inc[1] : b[0];
                        n_phase    = bmprld_pkg::PH_ABS;
                    end
                end
                bmprld_pkg::PH_DELTA_X: begin
                    n_delta_col = b;
                    n_phase     = bmprld_pkg::PH_DELTA_Y;
                end
                bmprld_pkg::PH_DELTA_Y: begin
                    if (row_end) begin
                        emit      = 1'b1;
                        emit_done = 1'b1;
                    end else begin
                        n_row       = row_sum[ROW_W-1:0];
                        col_adv     = n_delta_col;
                        do_adv      = 1'b1;
                        n_delta_col = '0;
                        n_phase     = bmprld_pkg::PH_COUNT;
                    end
                end
                bmprld_pkg::PH_ABS: begin
                    emit   = 1'b1;
                    do_adv = 1'b1;
                    if (r_four_bit_mode) begin
                        col_adv = (n_pix_left >= 8'd2) ? 8'd2 : 8'd1;
                        emit_a  = {4'd0, hi};
                        emit_b  = {4'd0, lo};
                    end else begin
                        col_adv = 8'd1;
                        emit_a  = b;
                        emit_b  = b;
                    end
                    emit_len   = col_adv;
                    n_pix_left = (n_pix_left > col_adv) ? n_pix_left - col_adv : 8'd0;
                    if (n_pix_left == 8'd0) begin
                        n_phase = n_pad ? bmprld_pkg::PH_PAD : bmprld_pkg::PH_COUNT;
                    end
                end
                bmprld_pkg::PH_PAD: begin
                    n_pad   = 1'b0;
                    n_phase = bmprld_pkg::PH_COUNT;
                end
                default: begin
                    n_phase     = bmprld_pkg::PH_COUNT;
                    n_pending   = '0;
                    n_pix_left  = '0;
                    n_pad       = 1'b0;
                    n_delta_col = '0;
                end
            endcase

            if (emit_done) begin
                n_done      = 1'b1;
                n_phase     = bmprld_pkg::PH_COUNT;
                n_pending   = '0;
                n_pix_left  = '0;
                n_pad       = 1'b0;
                n_delta_col = '0;
            end
        end

        col_sum = CSUM_W'(col_base) + CSUM_W'(col_adv);
        if (col_sum > COL_LAST) begin
            col_sum = COL_LAST;
        end
        n_col = col_clr ? '0 : (do_adv ? col_sum[COL_W-1:0] : col_base);
    end

    assign col_ext   = {12'd0, col_base};
    assign row_ext   = {12'd0, row_base};
    assign res_valid = accept && emit;

    always_comb begin
        res.row          = row_ext[11:0];
        res.start_column = col_ext[11:0];
        res.run_length   = emit_len;
        res.first_index  = emit_a;
        res.second_index = emit_b;
        res.image_done   = emit_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_four_bit_mode <= 1'b0;
            r_image_height  <= bmprld_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                bmprld_pkg::CFG_FOUR_BIT_MODE: r_four_bit_mode <= i_cfg_data[0];
                bmprld_pkg::CFG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= bmprld_pkg::PH_COUNT;
            r_pending   <= '0;
            r_pix_left  <= '0;
            r_pad       <= 1'b0;
            r_delta_col <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_done      <= 1'b0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_pending   <= n_pending;
            r_pix_left  <= n_pix_left;
            r_pad       <= n_pad;
            r_delta_col <= n_delta_col;
            r_col       <= n_col;
            r_row       <= n_row;
            r_done      <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.second_index, r_out.first_index, r_out.run_length,
                         r_out.start_column, r_out.row};
    assign o_m_tlast  = r_out.image_done;

endmodule

`default_nettype wire
